### hdl/iur_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Inverted UART receiver package
// Shared widths, register indexes, status codes and phase encoding.
// ----------------------------------------------------------------------------
package iur_pkg;

  localparam int DataBits   = 8;
  localparam int ByteW      = 8;
  localparam int PeriodW    = 16;
  localparam int TimeoutW   = 24;
  localparam int CfgIndexW  = 2;
  localparam int CfgDataW   = 24;
  localparam int StatusW    = 2;
  localparam int BitCountW  = 4;

  localparam logic [CfgIndexW-1:0] CfgBitPeriod     = 2'd0;
  localparam logic [CfgIndexW-1:0] CfgFirstSample   = 2'd1;
  localparam logic [CfgIndexW-1:0] CfgInitTimeout   = 2'd2;
  localparam logic [CfgIndexW-1:0] CfgFrameTimeout  = 2'd3;

  localparam logic [PeriodW-1:0]  BitPeriodReset    = 16'd104;
  localparam logic [PeriodW-1:0]  FirstSampleReset  = 16'd156;
  localparam logic [TimeoutW-1:0] InitTimeoutReset  = 24'd1000000;
  localparam logic [TimeoutW-1:0] FrameTimeoutReset = 24'd100000;

  typedef enum logic [StatusW-1:0] {
    ST_BYTE    = 2'd0,
    ST_FRAMING = 2'd1,
    ST_SILENCE = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    PH_HALTED = 4'b0001,
    PH_HUNT   = 4'b0010,
    PH_DATA   = 4'b0100,
    PH_STOP   = 4'b1000
  } phase_t;

endpackage

### hdl/inverted_uart_receiver_top.sv
`timescale 1ns / 1ps
// A result is registered; it reaches the master side in the cycle after its item.
// Throughput: one item per cycle while the output register is empty or being emptied.
// Each item is one tick of the line sampler, so frame timing is set by the counters.
// Reset: synchronous; state and configuration registers return to their defaults
// and the receiver sits halted until an item with restart set arrives.
// ----------------------------------------------------------------------------
// Inverted UART receiver
// Bit-timed 8N1 receiver for an idle-low line with start and stop checks and
// a silence timeout; emits the inverted data byte or an error status.
// ----------------------------------------------------------------------------
module inverted_uart_receiver_top
  import iur_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // Configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data,
  // Line ticks in
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // [0] line_level, [1] restart, rest zero
  // Results out
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [ByteW-1:0]     m_axis_tdata,   // [7:0] rx_byte
  output logic [StatusW-1:0]   m_axis_tuser    // [1:0] status
);

  // Configuration registers
  logic [PeriodW-1:0]  bit_period_ticks;
  logic [PeriodW-1:0]  first_sample_ticks;
  logic [TimeoutW-1:0] initial_timeout_ticks;
  logic [TimeoutW-1:0] frame_timeout_ticks;

  // Receiver state
  phase_t                phase, phase_next;
  logic [PeriodW-1:0]    tick_counter, tick_counter_next;
  logic [BitCountW-1:0]  bits_taken, bits_taken_next;
  logic [DataBits-1:0]   shift_value, shift_value_next;
  logic [TimeoutW-1:0]   timeout_counter, timeout_counter_next;

  // Output register
  logic                  out_valid;
  status_t               out_status;
  logic [ByteW-1:0]      out_byte;

  logic                  in_accept;
  logic                  line_level;
  logic                  restart;
  logic                  res_valid;
  status_t               res_status;
  logic [ByteW-1:0]      res_byte;
  logic [PeriodW-1:0]    tick_dec;
  logic [BitCountW-1:0]  bits_inc;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign line_level    = s_axis_tdata[0];
  assign restart       = s_axis_tdata[1];

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_byte;
  assign m_axis_tuser  = out_status;

  assign tick_dec = tick_counter - PeriodW'(1);
  assign bits_inc = bits_taken + BitCountW'(1);

  always_comb begin
    phase_next           = phase;
    tick_counter_next    = tick_counter;
    bits_taken_next      = bits_taken;
    shift_value_next     = shift_value;
    timeout_counter_next = timeout_counter;
    res_valid            = 1'b0;
    res_status           = ST_BYTE;
    res_byte             = '0;

    if (restart) begin
      phase_next           = PH_HUNT;
      timeout_counter_next = initial_timeout_ticks;
      tick_counter_next    = '0;
      bits_taken_next      = '0;
      shift_value_next     = '0;
    end else begin
      case (phase)
        PH_HALTED: begin
        end
        PH_HUNT: begin
          if (timeout_counter == '0) begin
            phase_next = PH_HALTED;
            res_valid  = 1'b1;
            res_status = ST_SILENCE;
          end else begin
            timeout_counter_next = timeout_counter - TimeoutW'(1);
            if (line_level) begin
              phase_next           = PH_DATA;
              tick_counter_next    = first_sample_ticks;
              timeout_counter_next = frame_timeout_ticks;
              bits_taken_next      = '0;
            end
          end
        end
        PH_DATA, PH_STOP: begin
          // The timeout keeps running through a frame but is only checked while hunting.
          if (timeout_counter != '0) begin
            timeout_counter_next = timeout_counter - TimeoutW'(1);
          end
          if (tick_dec != '0) begin
            tick_counter_next = tick_dec;
          end else begin
            tick_counter_next = bit_period_ticks;
            if (phase == PH_DATA) begin
              shift_value_next = {line_level, shift_value[DataBits-1:1]};
              bits_taken_next  = bits_inc;
              if (bits_inc >= BitCountW'(DataBits)) begin
                phase_next = PH_STOP;
              end
            end else if (line_level) begin
              phase_next = PH_HALTED;
              res_valid  = 1'b1;
              res_status = ST_FRAMING;
            end else begin
              phase_next      = PH_HUNT;
              bits_taken_next = '0;
              res_valid       = 1'b1;
              res_status      = ST_BYTE;
              res_byte        = ByteW'(~shift_value);
            end
          end
        end
        default: begin
          phase_next = PH_HALTED;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_period_ticks      <= BitPeriodReset;
      first_sample_ticks    <= FirstSampleReset;
      initial_timeout_ticks <= InitTimeoutReset;
      frame_timeout_ticks   <= FrameTimeoutReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CfgBitPeriod:    bit_period_ticks      <= cfg_data[PeriodW-1:0];
        CfgFirstSample:  first_sample_ticks    <= cfg_data[PeriodW-1:0];
        CfgInitTimeout:  initial_timeout_ticks <= cfg_data[TimeoutW-1:0];
        CfgFrameTimeout: frame_timeout_ticks   <= cfg_data[TimeoutW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HALTED;
      tick_counter    <= '0;
      bits_taken      <= '0;
      shift_value     <= '0;
      timeout_counter <= '0;
    end else if (in_accept) begin
      phase           <= phase_next;
      tick_counter    <= tick_counter_next;
      bits_taken      <= bits_taken_next;
      shift_value     <= shift_value_next;
      timeout_counter <= timeout_counter_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept && res_valid) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && res_valid) begin
      out_status <= res_status;
      out_byte   <= res_byte;
    end
  end

`ifndef ASSERT_OFF
  // Error results never carry data.
  a_error_no_data: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status != ST_BYTE) |-> (out_byte == '0))
    else $error("error result carries nonzero data");

  // The bit count never runs past the data width.
  a_bits_bounded: assert property (@(posedge clk) disable iff (rst)
    bits_taken <= BitCountW'(DataBits))
    else $error("bit count past data width");

  // Any error result leaves the receiver halted.
  a_error_halts: assert property (@(posedge clk) disable iff (rst)
    (in_accept && res_valid && res_status != ST_BYTE) |=> (phase == PH_HALTED))
    else $error("receiver not halted after error");

  // An empty output register always lets the next item in.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> s_axis_tready)
    else $error("input stalled with empty output register");
`endif

endmodule

### sim/uart_rx_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Inverted UART receiver checker
// Watches the configuration, line tick and result channels. It keeps its own
// model of the receiver and compares every result item against the oldest
// prediction.
// ----------------------------------------------------------------------------
module uart_rx_checker
  import iur_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // [0] line_level, [1] restart, rest zero
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic [ByteW-1:0]     m_axis_tdata,   // [7:0] rx_byte
  input  logic [StatusW-1:0]   m_axis_tuser,   // [1:0] status
  output int                   mismatch_count,
  output int                   outstanding
);

  localparam logic [ByteW-1:0] DataMask = ByteW'((1 << DataBits) - 1);

  typedef struct packed {
    status_t          status;
    logic [ByteW-1:0] rx_byte;
  } rx_result_t;

  rx_result_t expected_rx_q[$];
  rx_result_t oldest;

  // Register copies
  logic [PeriodW-1:0]  bit_period;
  logic [PeriodW-1:0]  first_sample;
  logic [TimeoutW-1:0] init_timeout;
  logic [TimeoutW-1:0] frame_timeout;

  // Receiver state
  phase_t              rx_phase;
  logic [PeriodW-1:0]  tick_cnt;
  logic [BitCountW-1:0] bits_taken;
  logic [ByteW-1:0]    shift_val;
  logic [TimeoutW-1:0] silence_cnt;

  task automatic push_result(input status_t status, input logic [ByteW-1:0] value);
    rx_result_t item;
    item.status  = status;
    item.rx_byte = value;
    expected_rx_q.push_back(item);
  endtask

  // One line tick: advances the receiver and queues the result it causes, if any.
  task automatic advance_line_tick(input logic lvl, input logic rs);
    if (rs) begin
      rx_phase    = PH_HUNT;
      silence_cnt = init_timeout;
      tick_cnt    = '0;
      bits_taken  = '0;
      shift_val   = '0;
    end else if (rx_phase == PH_HUNT) begin
      if (silence_cnt == '0) begin
        rx_phase = PH_HALTED;
        push_result(ST_SILENCE, '0);
      end else begin
        silence_cnt = silence_cnt - 1'b1;
        if (lvl) begin
          rx_phase    = PH_DATA;
          tick_cnt    = first_sample;
          silence_cnt = frame_timeout;
          bits_taken  = '0;
        end
      end
    end else if (rx_phase == PH_DATA || rx_phase == PH_STOP) begin
      // The silence timer keeps running inside a frame but is only checked while hunting.
      if (silence_cnt != '0) silence_cnt = silence_cnt - 1'b1;
      tick_cnt = tick_cnt - 1'b1;
      if (tick_cnt == '0) begin
        tick_cnt = bit_period;
        if (rx_phase == PH_DATA) begin
          shift_val  = ((shift_val >> 1) | (ByteW'(lvl) << (DataBits - 1))) & DataMask;
          bits_taken = bits_taken + 1'b1;
          if (bits_taken >= DataBits) rx_phase = PH_STOP;
        end else if (lvl) begin
          rx_phase = PH_HALTED;
          push_result(ST_FRAMING, '0);
        end else begin
          rx_phase   = PH_HUNT;
          bits_taken = '0;
          push_result(ST_BYTE, ~shift_val & DataMask);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      bit_period    = BitPeriodReset;
      first_sample  = FirstSampleReset;
      init_timeout  = InitTimeoutReset;
      frame_timeout = FrameTimeoutReset;
      rx_phase      = PH_HALTED;
      tick_cnt      = '0;
      bits_taken    = '0;
      shift_val     = '0;
      silence_cnt   = '0;
      expected_rx_q.delete();
    end else begin
      // Results at this edge stem from earlier ticks, so compare before predicting.
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_rx_q.size() == 0) begin
          $display("%0t: unexpected result, status %0d byte 0x%02h", $time,
                   m_axis_tuser, m_axis_tdata);
          mismatch_count++;
        end else begin
          oldest = expected_rx_q.pop_front();
          if (m_axis_tuser !== oldest.status) begin
            $display("%0t: status expected %0d actual %0d", $time, oldest.status,
                     m_axis_tuser);
            mismatch_count++;
          end
          if (m_axis_tdata !== oldest.rx_byte) begin
            $display("%0t: rx_byte expected 0x%02h actual 0x%02h", $time, oldest.rx_byte,
                     m_axis_tdata);
            mismatch_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CfgBitPeriod:    bit_period    = cfg_data[PeriodW-1:0];
          CfgFirstSample:  first_sample  = cfg_data[PeriodW-1:0];
          CfgInitTimeout:  init_timeout  = cfg_data[TimeoutW-1:0];
          CfgFrameTimeout: frame_timeout = cfg_data[TimeoutW-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) advance_line_tick(s_axis_tdata[0], s_axis_tdata[1]);
    end
    outstanding <= expected_rx_q.size();
  end

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Inverted UART receiver testbench
// Feeds line ticks that form inverted 8N1 frames, broken frames and noise
// under several timing settings, with random idling on both streams, and
// reports the verdict from the checker's mismatch and outstanding counts.
// ----------------------------------------------------------------------------
module testbench;
  import iur_pkg::*;

  localparam int HoldCycles = 400;
  localparam int DrainLimit = 5000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0]  cfg_data = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [ByteW-1:0]     m_axis_tdata;
  logic [StatusW-1:0]   m_axis_tuser;
  int                   mismatch_count;
  int                   outstanding;

  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  logic hold_toggle = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;
  int   cur_period = BitPeriodReset;
  int   cur_first = FirstSampleReset;
  int   ticks_sent = 0;

  always #1 clk = ~clk;

  inverted_uart_receiver_top dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  uart_rx_checker rx_check (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tuser   (m_axis_tuser),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  // Result side: random stalls, plus one long hold-off on request.
  always @(posedge clk) begin
    if (hold_toggle != hold_seen) begin
      hold_seen     <= hold_toggle;
      hold_left     <= HoldCycles;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_tick(input logic lvl, input logic rs);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, rs, lvl};
    // Ready is taken as it stands at the edge, before the block updates.
    @(posedge clk iff s_axis_tready);
    ticks_sent++;
  endtask

  // Start tick, then each line bit held up to its sample tick, then the stop level.
  // Noisy frames get glitches on ticks that are not sampled.
  task automatic send_frame(input logic [7:0] line_bits, input logic stop_lvl, input bit noisy);
    int   t;
    int   k;
    int   next_sample;
    logic lvl;
    send_tick(1'b1, 1'b0);
    next_sample = cur_first;
    k = 0;
    for (t = 1; k <= DataBits; t++) begin
      lvl = (k < DataBits) ? line_bits[k] : stop_lvl;
      if (t == next_sample) begin
        send_tick(lvl, 1'b0);
        k++;
        next_sample += cur_period;
      end else begin
        send_tick((noisy && $urandom_range(7) == 0) ? ~lvl : lvl, 1'b0);
      end
    end
  endtask

  task automatic put_reg(input logic [CfgIndexW-1:0] idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CfgDataW'(value);
    @(posedge clk iff cfg_ready);
  endtask

  task automatic write_cfg(input int period, input int first, input int init_to,
                           input int frame_to);
    put_reg(CfgBitPeriod, period);
    put_reg(CfgFirstSample, first);
    put_reg(CfgInitTimeout, init_to);
    put_reg(CfgFrameTimeout, frame_to);
    cfg_valid <= 1'b0;
    cur_period = period;
    cur_first  = first;
  endtask

  // Stop ticks and wait, up to DrainLimit, for every predicted result to be taken.
  task automatic settle();
    int waited;
    waited = 0;
    s_axis_tvalid <= 1'b0;
    repeat (2) @(posedge clk);
    while (outstanding != 0 && waited < DrainLimit) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int         mode;
    int         frames;
    int         mode_start;
    int         kind;
    int         gap;
    logic [7:0] bits;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 20;
    recv_idle_pct = 67;

    // A halted receiver ignores a high line until restart.
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    repeat (20) send_tick(1'b0, 1'b0);
    settle();

    write_cfg(1, 1, 40, 400);
    send_tick(1'b0, 1'b1);
    send_frame(8'hFF, 1'b0, 1'b0);
    send_frame(8'h00, 1'b0, 1'b0);
    send_frame(8'h5A, 1'b0, 1'b1);
    send_frame(8'h3C, 1'b1, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    // Restart in the middle of a frame, with the line high on the restart tick.
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b1);
    send_frame(8'h81, 1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    repeat (45) send_tick(1'b0, 1'b0);
    settle();

    // Shortest timeouts: silence expires on the second hunting tick, and a frame
    // that outlasts its timeout is followed by an immediate timeout.
    write_cfg(2, 3, 1, 1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_frame(8'h96, 1'b0, 1'b0);
    send_tick(1'b0, 1'b0);

    for (mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 20 : (mode == 1) ? 67 : 0;
      recv_idle_pct = (mode == 0) ? 67 : (mode == 1) ? 20 : 0;
      mode_start = ticks_sent;
      frames = 0;
      while (ticks_sent - mode_start < 250 || frames < 6) begin
        settle();
        write_cfg(($urandom_range(9) == 0) ? $urandom_range(1, 12) : $urandom_range(1, 4),
                  $urandom_range(1, 10),
                  $urandom_range(1) ? $urandom_range(500, 16777215) : $urandom_range(1, 60),
                  ($urandom_range(9) < 7) ? $urandom_range(200, 16777215) :
                                            $urandom_range(1, 80));
        // Hold the result side off long enough that the input stalls behind it.
        if (mode == 0 && frames == 0) hold_toggle <= ~hold_toggle;
        send_tick(1'b0, 1'b1);
        repeat ($urandom_range(4, 10)) begin
          kind = $urandom_range(99);
          bits = 8'($urandom);
          if ($urandom_range(9) == 0) send_tick(1'($urandom_range(1)), 1'b1);
          if (kind < 80) begin
            send_frame(bits, 1'b0, $urandom_range(3) == 0);
          end else if (kind < 88) begin
            send_frame(bits, 1'b1, 1'b0);
            send_tick(1'b0, 1'b1);
          end else if (kind < 94) begin
            send_tick(1'b1, 1'b0);
            repeat ($urandom_range(1, cur_first + 4 * cur_period))
              send_tick(1'($urandom_range(1)), 1'b0);
            send_tick(1'($urandom_range(1)), 1'b1);
          end else begin
            repeat ($urandom_range(1, 20))
              send_tick(1'($urandom_range(1)), $urandom_range(15) == 0);
          end
          gap = ($urandom_range(4) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 4);
          repeat (gap) send_tick(1'b0, 1'b0);
          frames++;
        end
      end
    end

    // Longest cell and first-sample delay with the largest timeouts: a frame that
    // starts and is cut short by a restart.
    settle();
    write_cfg(65535, 65535, 16777215, 16777215);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b0);
    repeat (20) send_tick(1'($urandom_range(1)), 1'b0);
    send_tick(1'b0, 1'b1);
    repeat (3) send_tick(1'b0, 1'b0);

    settle();
    if (outstanding != 0) $display("%0t: %0d results never arrived", $time, outstanding);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
